// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hctpt_pkg.sv =====
`default_nettype none
package hctpt_pkg;

  localparam int unsigned ENTRIES_DEF      = 1024;
  localparam int unsigned HIT_SATURATE_DEF = 1023;

  localparam int unsigned HOT_HITS  = 800;
  localparam int unsigned WARM_HITS = 300;
  localparam int unsigned COLD_HITS = 500;

  localparam logic [23:0] MEM_CAP_RST = 24'd1000000;
  localparam logic [23:0] SSD_CAP_RST = 24'd10000000;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_DEL    = 3'd1;
  localparam logic [2:0] KIND_ACCESS = 3'd2;
  localparam logic [2:0] KIND_MOVE   = 3'd3;
  localparam logic [2:0] KIND_REBAL  = 3'd4;
  localparam logic [2:0] KIND_DEMOTE = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADTIER  = 2'd3;

  localparam logic [1:0] TIER_MEM   = 2'd0;
  localparam logic [1:0] TIER_FLASH = 2'd1;
  localparam logic [1:0] TIER_HDD   = 2'd2;
  localparam logic [1:0] TIER_BAD   = 2'd3;

  localparam logic [1:0] CFG_MEM_CAP = 2'd0;
  localparam logic [1:0] CFG_SSD_CAP = 2'd1;
  localparam logic [1:0] CFG_DEMOTE  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] entry_id;
    logic [1:0]  req_tier;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  entry_tier;
    logic [10:0] moved_count;
    logic [10:0] mem_total;
    logic [10:0] flash_total;
    logic [10:0] disk_count;
    logic [31:0] switch_total;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/hot_cold_tier_placement_table.sv =====
// Hot/cold tier placement table. Holds up to ENTRIES ids, each with a tier
// (memory, ssd, disk) and a saturating hit count, in three synchronous
// memories with registered read data and separate read and write ports.
// One transfer in gives one transfer out. Add, delete, access and move scan
// the stored slots for the id, one per cycle; then come a step to act on the
// found slot, one more for a delete that refills the gap from the last slot,
// and the load of the output register. An add to a full table also scans
// first. Rebalance and an active demote spend a read and a write-back step
// per slot; a demote stops once it has moved its quota. A move to the
// invalid tier, a demote with nothing to do and unused kinds go straight to
// the output register without a scan. Items are processed one at a time,
// with an idle state between them. The result sits in an output register;
// the next item is taken once the controller is idle and that register can
// take a new result. Memories need no clearing: only slots below
// entry_count are read.
`default_nettype none
`include "assert_macros.svh"
module hot_cold_tier_placement_table #(
  parameter int unsigned ENTRIES      = hctpt_pkg::ENTRIES_DEF,
  parameter int unsigned HIT_SATURATE = hctpt_pkg::HIT_SATURATE_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  hctpt_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output hctpt_pkg::out_item_t  out_data,
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_index,
  input  wire  [23:0]           cfg_wdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int HW = $clog2(HIT_SATURATE + 1);

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1; // issue reads / compare ids
  localparam logic [2:0] S_ACT   = 3'd2; // act on a found slot
  localparam logic [2:0] S_LAST  = 3'd3; // delete: write last slot data into the gap
  localparam logic [2:0] S_WALK  = 3'd4; // rebalance/demote read
  localparam logic [2:0] S_WWB   = 3'd5; // rebalance/demote write-back
  localparam logic [2:0] S_DONE  = 3'd6;

  // memories
  logic [31:0]   id_mem   [ENTRIES];
  logic [1:0]    tier_mem [ENTRIES];
  logic [HW-1:0] hit_mem  [ENTRIES];
  logic [31:0]   rd_id;
  logic [1:0]    rd_tier;
  logic [HW-1:0] rd_hit;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [31:0]   wr_id;
  logic [1:0]    wr_tier;
  logic [HW-1:0] wr_hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[mem_wa]   <= wr_id;
      tier_mem[mem_wa] <= wr_tier;
      hit_mem[mem_wa]  <= wr_hit;
    end
    if (mem_re) begin
      rd_id   <= id_mem[mem_ra];
      rd_tier <= tier_mem[mem_ra];
      rd_hit  <= hit_mem[mem_ra];
    end
  end

  // control and counters
  logic [2:0]  state_r, state_nxt;
  hctpt_pkg::in_item_t item_r, item_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // slot being read
  logic          pend_r, pend_nxt;    // read data of slot idx_r-1 arriving
  logic [AW-1:0] pos_r, pos_nxt;
  logic [1:0]    etier_r, etier_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CW-1:0] moved_r, moved_nxt;
  logic [CW-1:0] quota_r, quota_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] tc_r [3];
  logic [CW-1:0] tc_nxt [3];
  logic [31:0]   sw_r, sw_nxt;
  logic [23:0]   mcap_r, scap_r;
  logic          dem_en_r;
  logic          ov_r, ov_nxt;
  hctpt_pkg::out_item_t od_r, od_nxt;

  logic out_free;
  logic [1:0] place;
  logic [1:0] want;
  logic [24:0] excess;

  assign out_free  = !ov_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcap_r   <= hctpt_pkg::MEM_CAP_RST;
      scap_r   <= hctpt_pkg::SSD_CAP_RST;
      dem_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hctpt_pkg::CFG_MEM_CAP: mcap_r   <= cfg_wdata;
        hctpt_pkg::CFG_SSD_CAP: scap_r   <= cfg_wdata;
        hctpt_pkg::CFG_DEMOTE:  dem_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (item_r.req_tier == hctpt_pkg::TIER_FLASH ||
        item_r.req_tier == hctpt_pkg::TIER_HDD)
      place = item_r.req_tier;
    else if (25'(tc_r[0]) < {1'b0, mcap_r}) place = hctpt_pkg::TIER_MEM;
    else if (25'(tc_r[1]) < {1'b0, scap_r}) place = hctpt_pkg::TIER_FLASH;
    else place = hctpt_pkg::TIER_HDD;
    if (32'(rd_hit) > hctpt_pkg::HOT_HITS) want = hctpt_pkg::TIER_MEM;
    else if (32'(rd_hit) > hctpt_pkg::WARM_HITS) want = hctpt_pkg::TIER_FLASH;
    else want = hctpt_pkg::TIER_HDD;
    excess = 25'(tc_r[0]) - {1'b0, mcap_r};
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    idx_nxt    = idx_r;
    pend_nxt   = 1'b0;
    pos_nxt    = pos_r;
    etier_nxt  = etier_r;
    status_nxt = status_r;
    moved_nxt  = moved_r;
    quota_nxt  = quota_r;
    cnt_nxt    = cnt_r;
    for (int t = 0; t < 3; t++) tc_nxt[t] = tc_r[t];
    sw_nxt     = sw_r;
    ov_nxt     = ov_r && out_stall;
    od_nxt     = od_r;
    mem_re = 1'b0; mem_ra = idx_r[AW-1:0];
    mem_we = 1'b0; mem_wa = pos_r;
    wr_id = rd_id; wr_tier = rd_tier; wr_hit = rd_hit;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && out_free) begin
          item_nxt   = in_data;
          idx_nxt    = '0;
          status_nxt = hctpt_pkg::ST_OK;
          etier_nxt  = hctpt_pkg::TIER_MEM;
          moved_nxt  = '0;
          quota_nxt  = '0;
          if (in_data.kind == hctpt_pkg::KIND_REBAL) state_nxt = S_WALK;
          else if (in_data.kind == hctpt_pkg::KIND_DEMOTE) begin
            state_nxt = S_DONE;
            if (dem_en_r && 25'(tc_r[0]) > {1'b0, mcap_r}) begin
              state_nxt = S_WALK;
              quota_nxt = CW'(excess >> 1);
            end
          end else if (in_data.kind == hctpt_pkg::KIND_MOVE &&
                       in_data.req_tier == hctpt_pkg::TIER_BAD) begin
            status_nxt = hctpt_pkg::ST_BADTIER;
            state_nxt  = S_DONE;
          end else if (in_data.kind <= hctpt_pkg::KIND_MOVE) state_nxt = S_SCAN;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (pend_r && rd_id == item_r.entry_id) begin
          pos_nxt   = AW'(idx_r - 1'b1);
          state_nxt = S_ACT;
        end else if (idx_r < cnt_r) begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          // not found
          if (item_r.kind == hctpt_pkg::KIND_ADD) begin
            if (32'(cnt_r) >= ENTRIES) status_nxt = hctpt_pkg::ST_FULL;
            else begin
              mem_we  = 1'b1;
              mem_wa  = cnt_r[AW-1:0];
              wr_id   = item_r.entry_id;
              wr_tier = place;
              wr_hit  = '0;
              cnt_nxt = cnt_r + 1'b1;
              tc_nxt[place] = tc_r[place] + 1'b1;
              etier_nxt = place;
            end
          end else status_nxt = hctpt_pkg::ST_NOTFOUND;
          state_nxt = S_DONE;
        end
      end
      S_ACT: begin
        etier_nxt = rd_tier;
        state_nxt = S_DONE;
        unique case (item_r.kind)
          hctpt_pkg::KIND_DEL: begin
            tc_nxt[rd_tier] = tc_r[rd_tier] - 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            if (32'(pos_r) + 1 < 32'(cnt_r)) begin
              mem_re    = 1'b1;
              mem_ra    = AW'(cnt_r - 1'b1);
              state_nxt = S_LAST;
            end
          end
          hctpt_pkg::KIND_ACCESS: begin
            mem_we = 1'b1;
            if (32'(rd_hit) < HIT_SATURATE) wr_hit = rd_hit + 1'b1;
          end
          hctpt_pkg::KIND_MOVE: begin
            if (item_r.req_tier != rd_tier) begin
              mem_we  = 1'b1;
              wr_tier = item_r.req_tier;
              tc_nxt[rd_tier] = tc_r[rd_tier] - 1'b1;
              tc_nxt[item_r.req_tier] = tc_r[item_r.req_tier] + 1'b1;
              sw_nxt    = sw_r + 1'b1;
              etier_nxt = item_r.req_tier;
            end
          end
          default: ; // add of an existing id
        endcase
      end
      S_LAST: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_WALK: begin
        if (idx_r < cnt_r &&
            !(item_r.kind == hctpt_pkg::KIND_DEMOTE && moved_r >= quota_r)) begin
          mem_re    = 1'b1;
          pos_nxt   = idx_r[AW-1:0];
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WWB;
        end else state_nxt = S_DONE;
      end
      S_WWB: begin
        state_nxt = S_WALK;
        if (item_r.kind == hctpt_pkg::KIND_REBAL) begin
          if (want != rd_tier) begin
            mem_we  = 1'b1;
            wr_tier = want;
            tc_nxt[rd_tier] = tc_r[rd_tier] - 1'b1;
            tc_nxt[want] = tc_r[want] + 1'b1;
            sw_nxt    = sw_r + 1'b1;
            moved_nxt = moved_r + 1'b1;
          end
        end else if (rd_tier == hctpt_pkg::TIER_MEM &&
                     32'(rd_hit) < hctpt_pkg::COLD_HITS) begin
          mem_we  = 1'b1;
          wr_tier = hctpt_pkg::TIER_FLASH;
          tc_nxt[0] = tc_r[0] - 1'b1;
          tc_nxt[1] = tc_r[1] + 1'b1;
          sw_nxt    = sw_r + 1'b1;
          moved_nxt = moved_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.status       = status_r;
          od_nxt.entry_tier   = etier_r;
          od_nxt.moved_count  = 11'(moved_r);
          od_nxt.mem_total    = 11'(tc_r[0]);
          od_nxt.flash_total  = 11'(tc_r[1]);
          od_nxt.disk_count   = 11'(tc_r[2]);
          od_nxt.switch_total = sw_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
      for (int t = 0; t < 3; t++) tc_r[t] <= '0;
      sw_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      for (int t = 0; t < 3; t++) tc_r[t] <= tc_nxt[t];
      sw_r    <= sw_nxt;
      ov_r    <= ov_nxt;
    end
    item_r   <= item_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    etier_r  <= etier_nxt;
    status_r <= status_nxt;
    moved_r  <= moved_nxt;
    quota_r  <= quota_nxt;
    od_r     <= od_nxt;
  end

  // entries never exceed table depth; tier totals sum to fill count (checked while idle); a taken item leaves idle
  `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, 32'(cnt_r) <= ENTRIES, "fill count overflow")
  `ASSERT_IMPLIES(a_tc_sum, clk, rst_n, state_r == S_IDLE,
    32'(tc_r[0]) + 32'(tc_r[1]) + 32'(tc_r[2]) == 32'(cnt_r), "tier totals mismatch")
  `ASSERT_NEXT(a_take_idle, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE,
    "item taken but controller idle")

endmodule
`default_nettype wire
